/* sv/tprc_pkg.sv */
// ----------------------------------------------------------------------------
// Tank pump rotation controller package
// Shared types, codes and reset values for the pump rotation controller.
// ----------------------------------------------------------------------------
package tprc_pkg;

    localparam int NUM_PUMPS = 3;

    localparam int LEVEL_W   = 10;
    localparam int FILL_W    = 4;
    localparam int DRAIN_W   = 3;
    localparam int MODE_W    = 2;
    localparam int RUNTIME_W = 32;
    localparam int INDEX_W   = 2;
    localparam int COUNT_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 10;

    typedef logic [MODE_W-1:0]    mode_t;
    typedef logic [LEVEL_W-1:0]   level_t;
    typedef logic [RUNTIME_W-1:0] runtime_t;
    typedef logic [COUNT_W-1:0]   count_t;

    typedef mode_t    [NUM_PUMPS-1:0] mode_vec_t;
    typedef runtime_t [NUM_PUMPS-1:0] runtime_vec_t;

    // Pump modes
    localparam mode_t MODE_IDLE   = 2'd0;
    localparam mode_t MODE_RUN    = 2'd1;
    localparam mode_t MODE_BROKEN = 2'd2;

    // Item commands
    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_TOGGLE = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOW_BAND  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_BAND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MAX = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_RATE = 2'd3;

    // Register reset values
    localparam level_t             LOW_BAND_RST  = 10'd250;
    localparam level_t             HIGH_BAND_RST = 10'd500;
    localparam level_t             LEVEL_MAX_RST = 10'd1000;
    localparam logic [FILL_W-1:0]  FILL_RATE_RST = 4'd2;

    localparam logic [DRAIN_W-1:0] DRAIN_LIMIT = 3'd4;
    localparam runtime_t           RUNTIME_MAX = '1;

    typedef struct packed {
        mode_vec_t    mode;
        runtime_vec_t runtime;
    } pump_state_t;

    typedef struct packed {
        logic                      cmd;
        logic [INDEX_W-1:0]        pump_index;
        logic [DRAIN_W-1:0]        drain_rate;
    } in_item_t;

endpackage

/* sv/tprc_if.sv */
// ----------------------------------------------------------------------------
// Tank pump rotation controller channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface tprc_in_if;
    import tprc_pkg::*;

    logic               valid;
    logic               ready;
    logic               cmd;
    logic [INDEX_W-1:0] pump_index;
    logic [DRAIN_W-1:0] drain_rate;

    modport source (output valid, output cmd, output pump_index, output drain_rate,
                    input ready);
    modport sink   (input valid, input cmd, input pump_index, input drain_rate,
                    output ready);
endinterface

interface tprc_out_if;
    import tprc_pkg::*;

    logic     valid;
    logic     ready;
    level_t   water_level;
    mode_t    pump0_mode;
    mode_t    pump1_mode;
    mode_t    pump2_mode;
    runtime_t pump0_runtime;
    runtime_t pump1_runtime;
    runtime_t pump2_runtime;

    modport source (output valid, output water_level,
                    output pump0_mode, output pump1_mode, output pump2_mode,
                    output pump0_runtime, output pump1_runtime, output pump2_runtime,
                    input ready);
    modport sink   (input valid, input water_level,
                    input pump0_mode, input pump1_mode, input pump2_mode,
                    input pump0_runtime, input pump1_runtime, input pump2_runtime,
                    output ready);
endinterface

/* sv/tprc_pump_select.sv */
// ----------------------------------------------------------------------------
// Pump selection
// Picks the running pumps for one tick and advances their run counters.
// ----------------------------------------------------------------------------
module tprc_pump_select (
    input  tprc_pkg::level_t      level,
    input  tprc_pkg::level_t      low_band,
    input  tprc_pkg::level_t      high_band,
    input  tprc_pkg::pump_state_t cur_state,
    output tprc_pkg::pump_state_t new_state,
    output tprc_pkg::count_t      run_count
);
    import tprc_pkg::*;

    count_t                 running;
    count_t                 target;
    logic                   hold;
    logic                   change;
    logic [NUM_PUMPS-1:0]   usable;
    logic [NUM_PUMPS-1:0]   picked;
    count_t                 rank [NUM_PUMPS];
    mode_vec_t              mode_sel;

    always_comb
    begin
        running = '0;
        for (int i = 0; i < NUM_PUMPS; i++)
        begin
            if (cur_state.mode[i] == MODE_RUN)
            begin
                running = running + count_t'(1);
            end
        end
    end

    // Target pump count from the level bands; exactly at high band keeps pumps
    always_comb
    begin
        hold   = 1'b0;
        target = '0;
        if (level < low_band)
        begin
            target = count_t'(2);
        end
        else if (level < high_band)
        begin
            target = count_t'(1);
        end
        else if (level > high_band)
        begin
            target = '0;
        end
        else
        begin
            hold = 1'b1;
        end
        change = !hold && (running != target);
    end

    // Rank each usable pump: least run time first, lower index on ties
    always_comb
    begin
        for (int i = 0; i < NUM_PUMPS; i++)
        begin
            usable[i] = (cur_state.mode[i] != MODE_BROKEN);
        end
        for (int i = 0; i < NUM_PUMPS; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < NUM_PUMPS; j++)
            begin
                if (j != i && usable[j] &&
                    ((cur_state.runtime[j] < cur_state.runtime[i]) ||
                     ((cur_state.runtime[j] == cur_state.runtime[i]) && (j < i))))
                begin
                    rank[i] = rank[i] + count_t'(1);
                end
            end
            picked[i] = usable[i] && (rank[i] < target);
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_PUMPS; i++)
        begin
            if (change && usable[i])
            begin
                mode_sel[i] = picked[i] ? MODE_RUN : MODE_IDLE;
            end
            else
            begin
                mode_sel[i] = cur_state.mode[i];
            end
        end
    end

    // Count run ticks, saturating at the top
    always_comb
    begin
        run_count      = '0;
        new_state.mode = mode_sel;
        for (int i = 0; i < NUM_PUMPS; i++)
        begin
            new_state.runtime[i] = cur_state.runtime[i];
            if (mode_sel[i] == MODE_RUN)
            begin
                run_count = run_count + count_t'(1);
                if (cur_state.runtime[i] != RUNTIME_MAX)
                begin
                    new_state.runtime[i] = cur_state.runtime[i] + runtime_t'(1);
                end
            end
        end
    end

endmodule

/* sv/tprc_level_update.sv */
// ----------------------------------------------------------------------------
// Level update
// Adds pump inflow, then removes drain, dropping steps that leave range.
// ----------------------------------------------------------------------------
module tprc_level_update (
    input  tprc_pkg::level_t               level,
    input  tprc_pkg::count_t               run_count,
    input  logic [tprc_pkg::FILL_W-1:0]    fill_rate,
    input  tprc_pkg::level_t               level_max,
    input  logic [tprc_pkg::DRAIN_W-1:0]   drain,
    output tprc_pkg::level_t               new_level
);
    import tprc_pkg::*;

    localparam int INFLOW_W = COUNT_W + FILL_W;

    logic [INFLOW_W-1:0] inflow;
    logic [LEVEL_W:0]    filled;
    level_t              level_fill;
    level_t              drained;
    logic                drop_drain;

    always_comb
    begin
        inflow     = INFLOW_W'(run_count) * INFLOW_W'(fill_rate);
        filled     = {1'b0, level} + (LEVEL_W + 1)'(inflow);
        level_fill = (filled > {1'b0, level_max}) ? level : filled[LEVEL_W-1:0];
        drained    = level_fill - LEVEL_W'(drain);
        drop_drain = (LEVEL_W'(drain) > level_fill) || (drained > level_max);
        new_level  = drop_drain ? level_fill : drained;
    end

endmodule

/* sv/tank_pump_rotation_controller_unit.sv */
// ----------------------------------------------------------------------------
// Tank pump rotation controller
// Level controller for three pumps with least-run-time rotation.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries items: a time tick (cmd 0, with drain_rate) or a toggle of
//   one pump's broken flag (cmd 1, with pump_index). out_ch returns one result
//   per item: the tank level and every pump's mode and run count after it.
//   The cfg_we / cfg_index / cfg_data port writes low_band, high_band,
//   level_max and fill_rate; write only while no item is in flight.
//   A result shows on out_ch after its input passes the input register, then
//   the result register. Throughput: one item per cycle while out_ch.ready
//   stays high; the state update is combinational logic between the two
//   registers, so an item can directly follow the one before it.
//   Reset clears the level, idles all pumps, zeroes run counts and loads the
//   register defaults (250, 500, 1000, 2); both stages come up empty.
//   When the receiver stalls, the result register holds its item and the
//   input register can still take one more; then in_ch.ready drops.
// ----------------------------------------------------------------------------
module tank_pump_rotation_controller_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    tprc_in_if.sink                            in_ch,
    tprc_out_if.source                         out_ch,
    input  logic                               cfg_we,
    input  logic [tprc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tprc_pkg::CFG_DAT_W-1:0]     cfg_data
);
    import tprc_pkg::*;

    // Configuration registers
    level_t              low_band_reg;
    level_t              high_band_reg;
    level_t              level_max_reg;
    logic [FILL_W-1:0]   fill_rate_reg;

    // Controller state
    level_t              level_reg;
    pump_state_t         pump_reg;

    // Input stage
    logic                stage_valid_reg;
    in_item_t            stage_reg;

    // Result stage
    logic                out_valid_reg;
    level_t              out_level_reg;
    pump_state_t         out_pump_reg;

    logic                in_xfer;
    logic                advance;
    logic [DRAIN_W-1:0]  drain;
    pump_state_t         tick_state;
    count_t              tick_runs;
    level_t              tick_level;
    level_t              level_next;
    pump_state_t         pump_next;

    // Advance the input stage when the result register is free or draining
    assign advance      = stage_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !stage_valid_reg || advance;
    assign in_xfer      = in_ch.valid && in_ch.ready;

    // Clamp the valve opening
    assign drain = (stage_reg.drain_rate > DRAIN_LIMIT) ? DRAIN_LIMIT
                                                        : stage_reg.drain_rate;

    tprc_pump_select u_select (
        .level     (level_reg),
        .low_band  (low_band_reg),
        .high_band (high_band_reg),
        .cur_state (pump_reg),
        .new_state (tick_state),
        .run_count (tick_runs)
    );

    tprc_level_update u_level (
        .level     (level_reg),
        .run_count (tick_runs),
        .fill_rate (fill_rate_reg),
        .level_max (level_max_reg),
        .drain     (drain),
        .new_level (tick_level)
    );

    // Pick the state after the staged item
    always_comb
    begin
        level_next = level_reg;
        pump_next  = pump_reg;
        if (stage_reg.cmd == CMD_TICK)
        begin
            level_next = tick_level;
            pump_next  = tick_state;
        end
        else
        begin
            // Toggle: broken goes idle, anything else goes broken; index 3 is ignored
            for (int i = 0; i < NUM_PUMPS; i++)
            begin
                if (stage_reg.pump_index == INDEX_W'(i))
                begin
                    pump_next.mode[i] = (pump_reg.mode[i] == MODE_BROKEN) ? MODE_IDLE
                                                                          : MODE_BROKEN;
                end
            end
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_band_reg  <= LOW_BAND_RST;
            high_band_reg <= HIGH_BAND_RST;
            level_max_reg <= LEVEL_MAX_RST;
            fill_rate_reg <= FILL_RATE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LOW_BAND:  low_band_reg  <= cfg_data[LEVEL_W-1:0];
                REG_HIGH_BAND: high_band_reg <= cfg_data[LEVEL_W-1:0];
                REG_LEVEL_MAX: level_max_reg <= cfg_data[LEVEL_W-1:0];
                REG_FILL_RATE: fill_rate_reg <= cfg_data[FILL_W-1:0];
                default:       low_band_reg  <= low_band_reg;
            endcase
        end
    end

    // Controller state: commit on every advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            for (int i = 0; i < NUM_PUMPS; i++)
            begin
                pump_reg.mode[i]    <= MODE_IDLE;
                pump_reg.runtime[i] <= '0;
            end
        end
        else if (advance)
        begin
            level_reg <= level_next;
            pump_reg  <= pump_next;
        end
    end

    // Input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            stage_reg.cmd        <= in_ch.cmd;
            stage_reg.pump_index <= in_ch.pump_index;
            stage_reg.drain_rate <= in_ch.drain_rate;
        end
    end

    // Result stage control: hold while the receiver stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_level_reg <= level_next;
            out_pump_reg  <= pump_next;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.water_level   = out_level_reg;
    assign out_ch.pump0_mode    = out_pump_reg.mode[0];
    assign out_ch.pump1_mode    = out_pump_reg.mode[1];
    assign out_ch.pump2_mode    = out_pump_reg.mode[2];
    assign out_ch.pump0_runtime = out_pump_reg.runtime[0];
    assign out_ch.pump1_runtime = out_pump_reg.runtime[1];
    assign out_ch.pump2_runtime = out_pump_reg.runtime[2];

endmodule

/* sv/tprc_checker.sv */
// ----------------------------------------------------------------------------
// Tank pump rotation controller checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module tprc_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               out_valid,
    input  logic               out_ready,
    input  tprc_pkg::level_t   water_level,
    input  tprc_pkg::mode_t    pump0_mode,
    input  tprc_pkg::mode_t    pump1_mode,
    input  tprc_pkg::mode_t    pump2_mode,
    input  tprc_pkg::runtime_t pump0_runtime,
    input  tprc_pkg::runtime_t pump1_runtime,
    input  tprc_pkg::runtime_t pump2_runtime
);
    import tprc_pkg::*;

    count_t runs;

    assign runs = count_t'(pump0_mode == MODE_RUN) + count_t'(pump1_mode == MODE_RUN)
                + count_t'(pump2_mode == MODE_RUN);

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result valid during reset");

    // A stalled result holds its payload
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(water_level)
            && $stable(pump0_mode) && $stable(pump1_mode) && $stable(pump2_mode)
            && $stable(pump0_runtime) && $stable(pump1_runtime) && $stable(pump2_runtime))
        else $error("stalled result changed");

    // Pump modes stay legal
    a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pump0_mode != 2'd3) && (pump1_mode != 2'd3) && (pump2_mode != 2'd3))
        else $error("illegal pump mode");

    // Rotation never runs more than two pumps
    a_two_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> runs <= count_t'(2))
        else $error("more than two pumps running");

endmodule

bind tank_pump_rotation_controller_unit tprc_checker u_tprc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .water_level   (out_ch.water_level),
    .pump0_mode    (out_ch.pump0_mode),
    .pump1_mode    (out_ch.pump1_mode),
    .pump2_mode    (out_ch.pump2_mode),
    .pump0_runtime (out_ch.pump0_runtime),
    .pump1_runtime (out_ch.pump1_runtime),
    .pump2_runtime (out_ch.pump2_runtime)
);

/* tb/tank_level_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tank pump rotation controller checker
// Watches the item, result and register ports. It keeps its own copy of the
// tank level, pump modes, run counts and settings, works out the state after
// each input transfer and compares it with the result transfers in order.
// ----------------------------------------------------------------------------
module tank_level_checker
    import tprc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    tprc_in_if                   in_ch,
    tprc_out_if                  out_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output int unsigned          states_awaited,
    output int unsigned          mismatch_count
);

    typedef struct packed {
        level_t       level;
        mode_vec_t    mode;
        runtime_vec_t hours;
    } tank_state_t;

    level_t            low_band_q;
    level_t            high_band_q;
    level_t            level_max_q;
    logic [FILL_W-1:0] fill_rate_q;

    level_t       tank_lvl;
    mode_vec_t    pump_mode;
    runtime_vec_t pump_hours;

    tank_state_t awaited_states[$];

    // Apply one item to the local copy and return the state it leaves.
    function automatic tank_state_t predict_tank_step(logic cmd, logic [INDEX_W-1:0] idx,
                                                      logic [DRAIN_W-1:0] drain_in);
        int unsigned running;
        int unsigned target;
        int unsigned drain;
        int unsigned filled;
        bit          restart;
        int          order[NUM_PUMPS];
        int          cnt;
        int          i;
        int          j;
        tank_state_t snap;

        drain = (drain_in > DRAIN_LIMIT) ? DRAIN_LIMIT : drain_in;
        if (cmd == CMD_TOGGLE)
        begin
            if (idx < NUM_PUMPS)
                pump_mode[idx] = (pump_mode[idx] == MODE_BROKEN) ? MODE_IDLE : MODE_BROKEN;
        end
        else
        begin
            running = 0;
            for (i = 0; i < NUM_PUMPS; i++)
                if (pump_mode[i] == MODE_RUN)
                    running++;

            target  = running;
            restart = 1'b0;
            if (tank_lvl < low_band_q)
            begin
                target  = 2;
                restart = (running != 2);
            end
            else if (tank_lvl < high_band_q)
            begin
                target  = 1;
                restart = (running != 1);
            end
            else if (tank_lvl > high_band_q)
            begin
                target  = 0;
                restart = (running != 0);
            end

            if (restart)
            begin
                // Insertion sort on run time; pumps come in index order, so a
                // tie keeps the lower index first.
                cnt = 0;
                for (i = 0; i < NUM_PUMPS; i++)
                begin
                    if (pump_mode[i] != MODE_BROKEN)
                    begin
                        pump_mode[i] = MODE_IDLE;
                        j = cnt;
                        while (j > 0 && pump_hours[i] < pump_hours[order[j-1]])
                        begin
                            order[j] = order[j-1];
                            j--;
                        end
                        order[j] = i;
                        cnt++;
                    end
                end
                running = 0;
                for (i = 0; i < cnt && i < int'(target); i++)
                begin
                    pump_mode[order[i]] = MODE_RUN;
                    running++;
                end
            end

            for (i = 0; i < NUM_PUMPS; i++)
                if (pump_mode[i] == MODE_RUN && pump_hours[i] != RUNTIME_MAX)
                    pump_hours[i] = pump_hours[i] + 1;

            // Fill, then drain; drop either update that leaves 0..level_max.
            filled = tank_lvl + running * fill_rate_q;
            if (filled <= level_max_q)
                tank_lvl = level_t'(filled);
            if (drain <= tank_lvl && tank_lvl - drain <= level_max_q)
                tank_lvl = level_t'(tank_lvl - drain);
        end

        snap.level = tank_lvl;
        snap.mode  = pump_mode;
        snap.hours = pump_hours;
        return snap;
    endfunction

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tank_state_t want;
        if (!rst_n)
        begin
            low_band_q  = LOW_BAND_RST;
            high_band_q = HIGH_BAND_RST;
            level_max_q = LEVEL_MAX_RST;
            fill_rate_q = FILL_RATE_RST;
            tank_lvl    = '0;
            pump_mode   = {NUM_PUMPS{MODE_IDLE}};
            pump_hours  = '0;
            awaited_states.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (awaited_states.size() == 0)
                begin
                    $error("result transfer with no state awaited");
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_states.pop_front();
                    check_field("water_level", 32'(want.level), 32'(out_ch.water_level));
                    check_field("pump0_mode", 32'(want.mode[0]), 32'(out_ch.pump0_mode));
                    check_field("pump1_mode", 32'(want.mode[1]), 32'(out_ch.pump1_mode));
                    check_field("pump2_mode", 32'(want.mode[2]), 32'(out_ch.pump2_mode));
                    check_field("pump0_runtime", want.hours[0], out_ch.pump0_runtime);
                    check_field("pump1_runtime", want.hours[1], out_ch.pump1_runtime);
                    check_field("pump2_runtime", want.hours[2], out_ch.pump2_runtime);
                end
            end

            // Append the predicted state at the tail of the queue
            if (in_ch.valid && in_ch.ready)
                awaited_states.insert(awaited_states.size(),
                                      predict_tank_step(in_ch.cmd, in_ch.pump_index,
                                                        in_ch.drain_rate));

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LOW_BAND:  low_band_q  = cfg_data;
                    REG_HIGH_BAND: high_band_q = cfg_data;
                    REG_LEVEL_MAX: level_max_q = cfg_data;
                    REG_FILL_RATE: fill_rate_q = cfg_data[FILL_W-1:0];
                    default:       ;
                endcase
            end
        end
        states_awaited = awaited_states.size();
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tank pump rotation controller testbench
// Drives ticks and pump toggles into the controller under a series of band,
// limit and fill settings, stalls both channels at random, and lets the
// checker compare every result with its own prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import tprc_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    // Random idling on both channels; cleared for a long clean stretch.
    bit idling_on;

    int unsigned states_awaited;
    int unsigned mismatch_count;

    tprc_in_if  in_ch ();
    tprc_out_if out_ch ();

    tank_pump_rotation_controller_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tank_level_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_ch          (in_ch),
        .out_ch         (out_ch),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .states_awaited (states_awaited),
        .mismatch_count (mismatch_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop well past the slowest legal run.
    initial
    begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: drop ready at random while idling is on.
    always @(negedge clk)
        out_ch.ready <= !idling_on || ($urandom_range(0, 99) >= 13);

    // Offer one item and hold it until the transfer. Called at a falling
    // edge; returns at the falling edge after the transfer with valid still
    // high, so the caller either offers the next item or lowers valid.
    task automatic send_item(logic cmd, logic [INDEX_W-1:0] idx, logic [DRAIN_W-1:0] drain);
        while (idling_on && $urandom_range(0, 99) < 13)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.cmd        <= cmd;
        in_ch.pump_index <= idx;
        in_ch.drain_rate <= drain;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Hold the sender until every awaited result has come, then let the
    // input and result registers empty.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (states_awaited != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    // Write all four registers back to back; only call after settle().
    task automatic load_settings(level_t lo, level_t hi, level_t lmax, logic [FILL_W-1:0] fill);
        cfg_we    <= 1'b1;
        cfg_index <= REG_LOW_BAND;
        cfg_data  <= lo;
        @(negedge clk);
        cfg_index <= REG_HIGH_BAND;
        cfg_data  <= hi;
        @(negedge clk);
        cfg_index <= REG_LEVEL_MAX;
        cfg_data  <= lmax;
        @(negedge clk);
        cfg_index <= REG_FILL_RATE;
        cfg_data  <= CFG_DAT_W'(fill);
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly ticks with a valve opening in the legal range; the rest are
    // toggles (out-of-range index now and then) and over-range openings.
    task automatic run_random(int count);
        int k;
        int pick;
        for (k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
                send_item(CMD_TOGGLE, INDEX_W'($urandom_range(0, 3)),
                          DRAIN_W'($urandom_range(0, 7)));
            else if (pick < 20)
                send_item(CMD_TICK, INDEX_W'($urandom_range(0, 3)),
                          DRAIN_W'($urandom_range(5, 7)));
            else
                send_item(CMD_TICK, INDEX_W'($urandom_range(0, 3)),
                          DRAIN_W'($urandom_range(0, 4)));
        end
    endtask

    initial
    begin
        int p;

        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.cmd        = CMD_TICK;
        in_ch.pump_index = '0;
        in_ch.drain_rate = '0;
        out_ch.ready     = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = REG_LOW_BAND;
        cfg_data         = '0;
        idling_on        = 1'b1;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: default settings, empty tank.
        send_item(CMD_TOGGLE, 2'd3, 3'd7);   // index out of range: no change
        send_item(CMD_TICK,   2'd0, 3'd0);   // two least-used pumps start
        send_item(CMD_TICK,   2'd3, 3'd7);   // opening saturates to the limit
        send_item(CMD_TICK,   2'd1, 3'd5);
        send_item(CMD_TOGGLE, 2'd0, 3'd0);   // break a running pump
        send_item(CMD_TICK,   2'd0, 3'd0);   // rotate onto the spare pump
        send_item(CMD_TICK,   2'd2, 3'd6);
        send_item(CMD_TOGGLE, 2'd0, 3'd0);   // repaired pump comes back idle
        send_item(CMD_TOGGLE, 2'd1, 3'd0);
        send_item(CMD_TOGGLE, 2'd2, 3'd0);
        send_item(CMD_TICK,   2'd0, 3'd4);   // only one pump left to run
        send_item(CMD_TICK,   2'd0, 3'd3);
        send_item(CMD_TOGGLE, 2'd1, 3'd7);
        send_item(CMD_TOGGLE, 2'd2, 3'd7);
        send_item(CMD_TICK,   2'd1, 3'd1);
        send_item(CMD_TICK,   2'd2, 3'd2);
        send_item(CMD_TOGGLE, 2'd0, 3'd4);
        send_item(CMD_TICK,   2'd0, 3'd0);
        send_item(CMD_TOGGLE, 2'd0, 3'd4);
        send_item(CMD_TICK,   2'd3, 3'd7);
        send_item(CMD_TICK,   2'd0, 3'd0);

        // Random phases, each under its own settings.
        run_random(300);

        // Limit far below the level: every update is dropped.
        settle();
        load_settings(10'd20, 10'd40, 10'd60, 4'd5);
        run_random(120);

        // Bands out of order, fastest fill.
        settle();
        load_settings(10'd600, 10'd300, 10'd1023, 4'd15);
        run_random(250);

        // Zero bands and no fill: drain to empty, then sit on the high band.
        settle();
        load_settings(10'd0, 10'd0, 10'd1023, 4'd0);
        run_random(150);

        // Top bands, full limit; one long stretch with no idling.
        settle();
        idling_on = 1'b0;
        load_settings(10'd1023, 10'd1023, 10'd1023, 4'd15);
        run_random(250);
        settle();
        idling_on = 1'b1;

        load_settings(10'd5, 10'd12, 10'd20, 4'd1);
        run_random(200);

        // Smallest legal limit.
        settle();
        load_settings(10'd1023, 10'd0, 10'd1, 4'd15);
        run_random(150);

        for (p = 0; p < 3; p++)
        begin
            settle();
            load_settings(level_t'($urandom_range(0, 1023)), level_t'($urandom_range(0, 1023)),
                          level_t'($urandom_range(1, 1023)), FILL_W'($urandom_range(0, 15)));
            run_random(150);
        end

        settle();
        repeat (5) @(negedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
